### rtl/core/semantic_version_parser_defines.svh
// Assertion macros for the checker file of the version parser.
`ifndef SEMANTIC_VERSION_PARSER_DEFINES_SVH
`define SEMANTIC_VERSION_PARSER_DEFINES_SVH

// Concurrent assertion on clk, disabled while rst is high.
`define SVP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion on clk that also runs through reset.
`define SVP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg
// Codes, character constants, tag word table and the status structs of the
// semantic version parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svp_pkg;

  // Characters of interest
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Section of the string
  localparam logic [1:0] SEC_MAIN = 2'd0;
  localparam logic [1:0] SEC_TAG  = 2'd1;
  localparam logic [1:0] SEC_META = 2'd2;

  // Component phases
  localparam logic [1:0] CPH_WS     = 2'd0;
  localparam logic [1:0] CPH_DIGITS = 2'd1;
  localparam logic [1:0] CPH_TRAIL  = 2'd2;
  localparam logic [1:0] CPH_BAD    = 2'd3;

  // Tag phases
  localparam logic [2:0] TPH_MATCH  = 3'd0;
  localparam logic [2:0] TPH_SEP    = 3'd1;
  localparam logic [2:0] TPH_PRE    = 3'd2;
  localparam logic [2:0] TPH_SIGN   = 3'd3;
  localparam logic [2:0] TPH_DIGITS = 3'd4;
  localparam logic [2:0] TPH_DONE   = 3'd5;
  localparam logic [2:0] TPH_NONUM  = 3'd6;
  localparam logic [2:0] TPH_DEAD   = 3'd7;

  // Tag kinds
  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_ALPHA = 2'd1;
  localparam logic [1:0] TAG_BETA  = 2'd2;
  localparam logic [1:0] TAG_RC    = 2'd3;

  // Error and status codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_TAG_MISSING = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW    = 2'd2;
  localparam logic [1:0] ERR_NOT_NUMERIC = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_COUNT  = 3'd4;

  localparam logic [2:0] PARTS_NEEDED  = 3'd3;
  localparam logic [2:0] COUNT_MAX     = 3'd7;

  // Result of the main-part tracker
  typedef struct packed {
    logic [30:0] major_part;
    logic [30:0] minor_part;
    logic [30:0] patch_part;
    logic [1:0]  comp_err;
    logic        count_three;
  } main_res_t;

  // Result of the tag tracker
  typedef struct packed {
    logic [1:0]  tag_kind;
    logic        has_tag_number;
    logic [31:0] tag_number;
    logic [1:0]  tag_err;
  } tag_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Character p of tag word k (alpha, beta, rc)
  function automatic logic [7:0] tag_word_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (p)
          3'd0: r = 8'h61;
          3'd1: r = 8'h6C;
          3'd2: r = 8'h70;
          3'd3: r = 8'h68;
          3'd4: r = 8'h61;
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (p)
          3'd0: r = 8'h62;
          3'd1: r = 8'h65;
          3'd2: r = 8'h74;
          3'd3: r = 8'h61;
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (p)
          3'd0: r = 8'h72;
          3'd1: r = 8'h63;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] tag_word_len(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd0:    r = 3'd5;
      2'd1:    r = 3'd4;
      2'd2:    r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/svp_acc.sv
// ----------------------------------------------------------------------------
// svp_acc
// Decimal digit accumulator: acc * 10 + digit with sticky overflow above
// 2^(VALUE_BITS-1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svp_acc #(
  parameter int VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0] acc,
  input  logic                  over,
  input  logic [3:0]            digit,
  output logic [VALUE_BITS-1:0] acc_next,
  output logic                  over_next
);

  localparam logic [VALUE_BITS+3:0] MAG_LIMIT = {{4{1'b0}}, 1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS+3:0] acc_wide;
  logic [VALUE_BITS+3:0] sum;

  // Shift-add times ten, then the digit
  assign acc_wide = {4'b0000, acc};
  assign sum      = (acc_wide << 3) + (acc_wide << 1) + {{VALUE_BITS{1'b0}}, digit};

  // Hold on overflow, otherwise take the new value
  always_comb begin
    acc_next  = acc;
    over_next = over;
    if (!over) begin
      if (sum > MAG_LIMIT) begin
        over_next = 1'b1;
      end else begin
        acc_next = sum[VALUE_BITS-1:0];
      end
    end
  end

endmodule

### rtl/core/svp_main.sv
// ----------------------------------------------------------------------------
// svp_main
// Section tracker and dot-separated component parser of the main version part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svp_main #(
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic              last,
  output logic              tag_en,
  output svp_pkg::main_res_t res
);

  typedef struct packed {
    logic [2:0]            index;
    logic [1:0]            phase;
    logic [VALUE_BITS-1:0] accum;
    logic                  over;
    logic [1:0]            err;
    logic [30:0]           p0;
    logic [30:0]           p1;
    logic [30:0]           p2;
  } comp_t;

  logic [1:0] section;
  logic [1:0] section_next;
  comp_t      comp;
  comp_t      comp_next;
  comp_t      comp_fin;

  logic [VALUE_BITS-1:0] acc_upd;
  logic                  over_upd;

  // Finish the open component and store its value
  function automatic comp_t close_comp(input comp_t s);
    comp_t                 r;
    logic [1:0]            e;
    logic [30:0]           val;
    logic [VALUE_BITS+30:0] wide;
    r    = s;
    e    = svp_pkg::ERR_NONE;
    val  = '0;
    wide = {{31{1'b0}}, s.accum};
    if (s.phase == svp_pkg::CPH_DIGITS || s.phase == svp_pkg::CPH_TRAIL) begin
      if (s.over || s.accum[VALUE_BITS-1]) begin
        e = svp_pkg::ERR_OVERFLOW;
      end else begin
        val = wide[30:0];
      end
    end else begin
      e = svp_pkg::ERR_NOT_NUMERIC;
    end
    if (s.err == svp_pkg::ERR_NONE) begin
      r.err = e;
    end
    case (s.index)
      3'd0:    r.p0 = val;
      3'd1:    r.p1 = val;
      3'd2:    r.p2 = val;
      default: ;
    endcase
    if (s.index < svp_pkg::COUNT_MAX) begin
      r.index = s.index + 3'd1;
    end
    r.phase = svp_pkg::CPH_WS;
    r.accum = '0;
    r.over  = 1'b0;
    return r;
  endfunction

  svp_acc #(
    .VALUE_BITS(VALUE_BITS)
  ) u_acc (
    .acc      (comp.accum),
    .over     (comp.over),
    .digit    (ch[3:0]),
    .acc_next (acc_upd),
    .over_next(over_upd)
  );

  // Advance section and component state by one character
  always_comb begin
    section_next = section;
    comp_next    = comp;
    tag_en       = (section == svp_pkg::SEC_TAG) && (ch != svp_pkg::CH_PLUS);
    unique case (section)
      svp_pkg::SEC_MAIN: begin
        if (ch == svp_pkg::CH_PLUS) begin
          comp_next    = close_comp(comp);
          section_next = svp_pkg::SEC_META;
        end else if (ch == svp_pkg::CH_MINUS) begin
          comp_next    = close_comp(comp);
          section_next = svp_pkg::SEC_TAG;
        end else if (ch == svp_pkg::CH_DOT) begin
          comp_next = close_comp(comp);
        end else begin
          case (comp.phase)
            svp_pkg::CPH_WS: begin
              if (svp_pkg::is_digit(ch)) begin
                comp_next.accum = acc_upd;
                comp_next.over  = over_upd;
                comp_next.phase = svp_pkg::CPH_DIGITS;
              end else if (!svp_pkg::is_ws(ch)) begin
                comp_next.phase = svp_pkg::CPH_BAD;
              end
            end
            svp_pkg::CPH_DIGITS: begin
              if (svp_pkg::is_digit(ch)) begin
                comp_next.accum = acc_upd;
                comp_next.over  = over_upd;
              end else begin
                comp_next.phase = svp_pkg::CPH_TRAIL;
              end
            end
            default: ;
          endcase
        end
      end
      svp_pkg::SEC_TAG: begin
        if (ch == svp_pkg::CH_PLUS) begin
          section_next = svp_pkg::SEC_META;
        end
      end
      default: ;
    endcase
  end

  // Close a component still open at the end of the string
  always_comb begin
    comp_fin = (section_next == svp_pkg::SEC_MAIN) ? close_comp(comp_next) : comp_next;
    res.major_part  = comp_fin.p0;
    res.minor_part  = comp_fin.p1;
    res.patch_part  = comp_fin.p2;
    res.comp_err    = comp_fin.err;
    res.count_three = (comp_fin.index == svp_pkg::PARTS_NEEDED);
  end

  // Hold state; return to the initial state after the last character
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      section <= svp_pkg::SEC_MAIN;
      comp    <= '0;
    end else if (step) begin
      section <= section_next;
      comp    <= comp_next;
    end
  end

endmodule

### rtl/core/svp_tag.sv
// ----------------------------------------------------------------------------
// svp_tag
// Pre-release tag parser: matches alpha, beta or rc, skips one separator and
// reads an optionally negative tag number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svp_tag #(
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              tag_en,
  input  logic [7:0]        ch,
  input  logic              last,
  output svp_pkg::tag_res_t res
);

  logic [2:0]            word_pos;
  logic [2:0]            word_pos_next;
  logic [2:0]            alive;
  logic [2:0]            alive_next;
  logic [1:0]            kind;
  logic [1:0]            kind_next;
  logic [VALUE_BITS-1:0] accum;
  logic [VALUE_BITS-1:0] accum_next;
  logic                  over;
  logic                  over_next;
  logic                  negative;
  logic                  negative_next;
  logic [2:0]            phase;
  logic [2:0]            phase_next;

  logic [VALUE_BITS-1:0] acc_upd;
  logic                  over_upd;
  logic [VALUE_BITS+31:0] mag_wide;
  logic [VALUE_BITS+31:0] neg_wide;

  svp_acc #(
    .VALUE_BITS(VALUE_BITS)
  ) u_acc (
    .acc      (accum),
    .over     (over),
    .digit    (ch[3:0]),
    .acc_next (acc_upd),
    .over_next(over_upd)
  );

  // Advance the tag state by one character
  always_comb begin
    word_pos_next = word_pos;
    alive_next    = alive;
    kind_next     = kind;
    accum_next    = accum;
    over_next     = over;
    negative_next = negative;
    phase_next    = phase;
    if (tag_en) begin
      case (phase)
        svp_pkg::TPH_MATCH: begin
          for (int k = 0; k < 3; k++) begin
            if (alive[k] && !((word_pos < svp_pkg::tag_word_len(2'(k))) &&
                (svp_pkg::tag_word_char(2'(k), word_pos) == ch))) begin
              alive_next[k] = 1'b0;
            end
          end
          if (word_pos < svp_pkg::COUNT_MAX) begin
            word_pos_next = word_pos + 3'd1;
          end
          for (int k = 0; k < 3; k++) begin
            if (alive_next[k] && (svp_pkg::tag_word_len(2'(k)) == word_pos_next)) begin
              kind_next  = 2'(k + 1);
              phase_next = svp_pkg::TPH_SEP;
            end
          end
          if (alive_next == 3'b000) begin
            phase_next = svp_pkg::TPH_DEAD;
          end
        end
        svp_pkg::TPH_SEP: begin
          phase_next = svp_pkg::TPH_PRE;
        end
        svp_pkg::TPH_PRE: begin
          if (svp_pkg::is_ws(ch)) begin
            phase_next = svp_pkg::TPH_PRE;
          end else if (ch == svp_pkg::CH_MINUS) begin
            negative_next = 1'b1;
            phase_next    = svp_pkg::TPH_SIGN;
          end else if (svp_pkg::is_digit(ch)) begin
            accum_next = acc_upd;
            over_next  = over_upd;
            phase_next = svp_pkg::TPH_DIGITS;
          end else begin
            phase_next = svp_pkg::TPH_NONUM;
          end
        end
        svp_pkg::TPH_SIGN: begin
          if (svp_pkg::is_digit(ch)) begin
            accum_next = acc_upd;
            over_next  = over_upd;
            phase_next = svp_pkg::TPH_DIGITS;
          end else begin
            phase_next = svp_pkg::TPH_NONUM;
          end
        end
        svp_pkg::TPH_DIGITS: begin
          if (svp_pkg::is_digit(ch)) begin
            accum_next = acc_upd;
            over_next  = over_upd;
          end else begin
            phase_next = svp_pkg::TPH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Evaluate the tag number at the end of the string
  always_comb begin
    mag_wide           = {{32{1'b0}}, accum_next};
    neg_wide           = -mag_wide;
    res.tag_kind       = kind_next;
    res.has_tag_number = 1'b0;
    res.tag_number     = '0;
    res.tag_err        = svp_pkg::ERR_NONE;
    if (kind_next != svp_pkg::TAG_NONE) begin
      case (phase_next)
        svp_pkg::TPH_PRE, svp_pkg::TPH_SIGN, svp_pkg::TPH_NONUM: begin
          res.tag_err = svp_pkg::ERR_TAG_MISSING;
        end
        svp_pkg::TPH_DIGITS, svp_pkg::TPH_DONE: begin
          if (over_next || (!negative_next && accum_next[VALUE_BITS-1])) begin
            res.tag_err = svp_pkg::ERR_OVERFLOW;
          end else begin
            res.has_tag_number = 1'b1;
            res.tag_number     = negative_next ? neg_wide[31:0] : mag_wide[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Hold state; return to the initial state after the last character
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      word_pos <= '0;
      alive    <= 3'b111;
      kind     <= svp_pkg::TAG_NONE;
      accum    <= '0;
      over     <= 1'b0;
      negative <= 1'b0;
      phase    <= svp_pkg::TPH_MATCH;
    end else if (step) begin
      word_pos <= word_pos_next;
      alive    <= alive_next;
      kind     <= kind_next;
      accum    <= accum_next;
      over     <= over_next;
      negative <= negative_next;
      phase    <= phase_next;
    end
  end

endmodule

### rtl/core/semantic_version_parser.sv
// ----------------------------------------------------------------------------
// semantic_version_parser
// Streaming semantic version string parser, one character per transfer.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per cycle on the s_ side and, on the
// character flagged by s_tlast, delivers one result on the m_ side: major,
// minor and patch numbers, the pre-release tag kind and number, and a status.
// Characters go into an input register; from there one pass of logic
// updates the parser state and, for the last character, loads the output
// register once it is free. The sustained rate is one character per cycle;
// it drops only while a finished result waits on m_tready and another
// string end arrives. Numbers are read with VALUE_BITS-bit signed range
// checks. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module semantic_version_parser #(
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] ch
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [30:0] major_part, [61:31] minor_part, [92:62] patch_part, [94:93] tag_kind,
  // [95] has_tag_number, [127:96] tag_number, [130:128] status, [135:131] zero
  output logic [135:0] m_tdata
);

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_last;
  logic       step;
  logic       tag_en;
  logic [2:0] status;

  svp_pkg::main_res_t main_res;
  svp_pkg::tag_res_t  tag_res;

  // Step when the character makes no result or the output slot frees up
  assign step     = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch   <= s_tdata;
      in_last <= s_tlast;
    end
  end

  svp_main #(
    .VALUE_BITS(VALUE_BITS)
  ) u_main (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .ch    (in_ch),
    .last  (in_last),
    .tag_en(tag_en),
    .res   (main_res)
  );

  svp_tag #(
    .VALUE_BITS(VALUE_BITS)
  ) u_tag (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .tag_en(tag_en),
    .ch    (in_ch),
    .last  (in_last),
    .res   (tag_res)
  );

  // Tag error first, then component error, then component count
  always_comb begin
    if (tag_res.tag_err != svp_pkg::ERR_NONE) begin
      status = {1'b0, tag_res.tag_err};
    end else if (main_res.comp_err != svp_pkg::ERR_NONE) begin
      status = {1'b0, main_res.comp_err};
    end else if (!main_res.count_three) begin
      status = svp_pkg::ST_BAD_COUNT;
    end else begin
      status = svp_pkg::ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      m_tdata <= {5'b00000, status, tag_res.tag_number, tag_res.has_tag_number,
                  tag_res.tag_kind, main_res.patch_part, main_res.minor_part,
                  main_res.major_part};
    end
  end

endmodule

### rtl/core/svp_checker.sv
// ----------------------------------------------------------------------------
// svp_checker
// Port-level checks of the semantic version parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "semantic_version_parser_defines.svh"

module svp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);

  // A stalled result holds
  `SVP_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "held result")

  // Reset empties the output register
  `SVP_ASSERT_RST(a_reset, rst |=> !m_tvalid, "result valid after reset")

  // Status stays within its codes
  `SVP_ASSERT(a_status, m_tvalid |-> m_tdata[130:128] <= svp_pkg::ST_BAD_COUNT, "bad status")

  // A tag number needs a recognized tag word
  `SVP_ASSERT(a_has_kind, m_tvalid && m_tdata[95] |-> |m_tdata[94:93], "untagged number")

  // A nonzero tag number is flagged
  `SVP_ASSERT(a_num_flag, m_tvalid && |m_tdata[127:96] |-> m_tdata[95], "unflagged number")

endmodule

bind semantic_version_parser svp_checker u_svp_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

### sim/semantic_version_parser_tb.sv
// ----------------------------------------------------------------------------
// semantic_version_parser_tb
// Self-checking testbench for the streaming semantic version parser.
// ----------------------------------------------------------------------------
// Strings are fed one character per transfer. A behavioral parser inside the
// bench follows every accepted character and queues the expected result for
// each string end. Results on the master side are compared field by field with
// the oldest queued one. A few hand-picked strings come first. Random version
// strings follow, mixed with byte noise, in three phases of back-pressure.
`timescale 1ns / 1ps

module semantic_version_parser_tb;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          PHASE_CHARS = 376;
  localparam longint unsigned NUM_LIMIT = 64'd1 << 31;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  // One result, laid out as m_tdata with major_part in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [2:0]  status;
    logic [31:0] tag_number;
    logic        has_tag_number;
    logic [1:0]  tag_kind;
    logic [30:0] patch_part;
    logic [30:0] minor_part;
    logic [30:0] major_part;
  } version_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;  // [7:0] ch
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [30:0] major_part, [61:31] minor_part, [92:62] patch_part, [94:93] tag_kind,
  // [95] has_tag_number, [127:96] tag_number, [130:128] status, [135:131] zero
  logic [135:0] m_tdata;

  semantic_version_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and checking state
  char_item_t pending_chars[$];
  version_t   expected_versions[$];
  logic [7:0] str_buf[$];
  int         chars_queued = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         hold_request = 1'b0;
  int         hold_left = 0;
  bit         took = 1'b0;

  // Parser state mirrored by the bench
  logic [1:0]      p_sec;
  logic [2:0]      p_comp_idx;
  logic [1:0]      p_comp_ph;
  longint unsigned p_num;
  bit              p_num_over;
  logic [30:0]     p_parts[3];
  logic [1:0]      p_comp_err;
  logic [2:0]      p_word_pos;
  logic [2:0]      p_alive;
  logic [1:0]      p_kind;
  longint unsigned p_tag_num;
  bit              p_tag_over;
  bit              p_tag_neg;
  logic [2:0]      p_tph;

  string      tag_names[3] = '{"alpha", "beta", "rc"};
  string      tag_stubs[3] = '{"alp", "bet", "r"};
  logic [1:0] tag_codes[3] = '{svp_pkg::TAG_ALPHA, svp_pkg::TAG_BETA, svp_pkg::TAG_RC};
  string      ws_chars = " \t\n\v\f\r";

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic bit is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return (c >= svp_pkg::CH_ZERO) && (c <= svp_pkg::CH_NINE);
  endfunction

  task automatic clear_parser();
    p_sec = svp_pkg::SEC_MAIN;
    p_comp_idx = '0;
    p_comp_ph = svp_pkg::CPH_WS;
    p_num = 0;
    p_num_over = 1'b0;
    p_parts = '{default: '0};
    p_comp_err = svp_pkg::ERR_NONE;
    p_word_pos = '0;
    p_alive = 3'b111;
    p_kind = svp_pkg::TAG_NONE;
    p_tag_num = 0;
    p_tag_over = 1'b0;
    p_tag_neg = 1'b0;
    p_tph = svp_pkg::TPH_MATCH;
  endtask

  // Add one decimal digit, latching overflow above 2^31
  task automatic add_digit(inout longint unsigned acc, inout bit over,
                           input logic [7:0] c);
    longint unsigned d;
    d = longint'(c - svp_pkg::CH_ZERO);
    if (!over) begin
      if (acc > (NUM_LIMIT - d) / 10) over = 1'b1;
      else acc = acc * 10 + d;
    end
  endtask

  // Close the current main-part component and store its value
  task automatic end_component();
    logic [1:0]  err;
    logic [30:0] val;
    err = svp_pkg::ERR_NONE;
    val = '0;
    if (p_comp_ph == svp_pkg::CPH_DIGITS || p_comp_ph == svp_pkg::CPH_TRAIL) begin
      if (p_num_over || p_num > NUM_LIMIT - 1) err = svp_pkg::ERR_OVERFLOW;
      else val = p_num[30:0];
    end else begin
      err = svp_pkg::ERR_NOT_NUMERIC;
    end
    if (p_comp_err == svp_pkg::ERR_NONE) p_comp_err = err;
    if (p_comp_idx < svp_pkg::PARTS_NEEDED) p_parts[p_comp_idx] = val;
    if (p_comp_idx < svp_pkg::COUNT_MAX) p_comp_idx++;
    p_comp_ph = svp_pkg::CPH_WS;
    p_num = 0;
    p_num_over = 1'b0;
  endtask

  task automatic tag_step(input logic [7:0] c);
    case (p_tph)
      svp_pkg::TPH_MATCH: begin
        // Drop every candidate word that disagrees at this position
        for (int k = 0; k < 3; k++) begin
          if (p_alive[k] && !(p_word_pos < tag_names[k].len() &&
                              tag_names[k][p_word_pos] == c))
            p_alive[k] = 1'b0;
        end
        if (p_word_pos < svp_pkg::COUNT_MAX) p_word_pos++;
        for (int k = 0; k < 3; k++) begin
          if (p_alive[k] && tag_names[k].len() == p_word_pos) begin
            p_kind = tag_codes[k];
            p_tph = svp_pkg::TPH_SEP;
          end
        end
        if (p_alive == 3'b000) p_tph = svp_pkg::TPH_DEAD;
      end
      svp_pkg::TPH_SEP: p_tph = svp_pkg::TPH_PRE;
      svp_pkg::TPH_PRE: begin
        if (is_space(c)) begin
        end else if (c == svp_pkg::CH_MINUS) begin
          p_tag_neg = 1'b1;
          p_tph = svp_pkg::TPH_SIGN;
        end else if (is_num(c)) begin
          add_digit(p_tag_num, p_tag_over, c);
          p_tph = svp_pkg::TPH_DIGITS;
        end else begin
          p_tph = svp_pkg::TPH_NONUM;
        end
      end
      svp_pkg::TPH_SIGN: begin
        if (is_num(c)) begin
          add_digit(p_tag_num, p_tag_over, c);
          p_tph = svp_pkg::TPH_DIGITS;
        end else begin
          p_tph = svp_pkg::TPH_NONUM;
        end
      end
      svp_pkg::TPH_DIGITS: begin
        if (is_num(c)) add_digit(p_tag_num, p_tag_over, c);
        else p_tph = svp_pkg::TPH_DONE;
      end
      default: ;
    endcase
  endtask

  // Follow one accepted character; queue a result on the string end
  task automatic parse_char(input logic [7:0] c, input logic last);
    version_t        want;
    logic [1:0]      tag_err;
    longint unsigned lim;
    if (p_sec == svp_pkg::SEC_MAIN) begin
      if (c == svp_pkg::CH_PLUS) begin
        end_component();
        p_sec = svp_pkg::SEC_META;
      end else if (c == svp_pkg::CH_MINUS) begin
        end_component();
        p_sec = svp_pkg::SEC_TAG;
      end else if (c == svp_pkg::CH_DOT) begin
        end_component();
      end else begin
        case (p_comp_ph)
          svp_pkg::CPH_WS: begin
            if (is_num(c)) begin
              add_digit(p_num, p_num_over, c);
              p_comp_ph = svp_pkg::CPH_DIGITS;
            end else if (!is_space(c)) begin
              p_comp_ph = svp_pkg::CPH_BAD;
            end
          end
          svp_pkg::CPH_DIGITS: begin
            if (is_num(c)) add_digit(p_num, p_num_over, c);
            else p_comp_ph = svp_pkg::CPH_TRAIL;
          end
          default: ;
        endcase
      end
    end else if (p_sec == svp_pkg::SEC_TAG) begin
      if (c == svp_pkg::CH_PLUS) p_sec = svp_pkg::SEC_META;
      else tag_step(c);
    end

    if (last) begin
      want = '0;
      tag_err = svp_pkg::ERR_NONE;
      if (p_sec == svp_pkg::SEC_MAIN) end_component();
      if (p_kind != svp_pkg::TAG_NONE) begin
        if (p_tph inside {svp_pkg::TPH_PRE, svp_pkg::TPH_SIGN, svp_pkg::TPH_NONUM}) begin
          tag_err = svp_pkg::ERR_TAG_MISSING;
        end else if (p_tph == svp_pkg::TPH_DIGITS || p_tph == svp_pkg::TPH_DONE) begin
          lim = p_tag_neg ? NUM_LIMIT : NUM_LIMIT - 1;
          if (p_tag_over || p_tag_num > lim) begin
            tag_err = svp_pkg::ERR_OVERFLOW;
          end else begin
            want.has_tag_number = 1'b1;
            want.tag_number = p_tag_neg ? 32'(64'd0 - p_tag_num) : 32'(p_tag_num);
          end
        end
      end
      // Tag error first, then the first component error, then the count
      if (tag_err != svp_pkg::ERR_NONE) want.status = {1'b0, tag_err};
      else if (p_comp_err != svp_pkg::ERR_NONE) want.status = {1'b0, p_comp_err};
      else if (p_comp_idx != svp_pkg::PARTS_NEEDED) want.status = svp_pkg::ST_BAD_COUNT;
      else want.status = svp_pkg::ST_OK;
      want.major_part = p_parts[0];
      want.minor_part = p_parts[1];
      want.patch_part = p_parts[2];
      want.tag_kind = p_kind;
      expected_versions = {expected_versions, want};
      clear_parser();
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic string version_text(input version_t v);
    return $sformatf("maj=%0d min=%0d pat=%0d kind=%0d has=%0d num=%0d st=%0d pad=%0d",
                     v.major_part, v.minor_part, v.patch_part, v.tag_kind,
                     v.has_tag_number, $signed(v.tag_number), v.status, v.pad);
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_version(input logic [135:0] data);
    version_t got;
    version_t want;
    string    bad;
    got = version_t'(data);
    bad = "";
    if (expected_versions.size() == 0) begin
      log_mismatch({"unexpected result ", version_text(got)});
    end else begin
      want = expected_versions.pop_front();
      if (got.major_part !== want.major_part) bad = {bad, " major_part"};
      if (got.minor_part !== want.minor_part) bad = {bad, " minor_part"};
      if (got.patch_part !== want.patch_part) bad = {bad, " patch_part"};
      if (got.tag_kind !== want.tag_kind) bad = {bad, " tag_kind"};
      if (got.has_tag_number !== want.has_tag_number) bad = {bad, " has_tag_number"};
      if (got.tag_number !== want.tag_number) bad = {bad, " tag_number"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.pad !== want.pad) bad = {bad, " pad"};
      if (bad != "")
        log_mismatch({"field", bad, "\n  expected ", version_text(want),
                      "\n  actual   ", version_text(got)});
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next character at the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    took = !rst && s_tvalid && s_tready;
    if (took) parse_char(s_tdata, s_tlast);
  end

  always @(negedge clk) begin
    char_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took) begin
      if (pending_chars.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        item = pending_chars.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= item.ch;
        s_tlast <= item.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results at the rising edge, stall at the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_version(m_tdata);
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL semantic_version_parser");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // String generation
  // --------------------------------------------------------------------------
  task automatic put(input string t);
    for (int i = 0; i < t.len(); i++) str_buf = {str_buf, t[i]};
  endtask

  task automatic put_byte(input logic [7:0] b);
    str_buf = {str_buf, b};
  endtask

  task automatic put_ws();
    put_byte(ws_chars[$urandom_range(ws_chars.len() - 1)]);
  endtask

  // Move the built string into the send queue, flagging its last character
  task automatic send_string();
    for (int i = 0; i < str_buf.size(); i++)
      pending_chars = {pending_chars, char_item_t'{str_buf[i], i == str_buf.size() - 1}};
    chars_queued += str_buf.size();
    str_buf.delete();
  endtask

  function automatic string number_text();
    int r;
    r = $urandom_range(9);
    if (r < 4) return $sformatf("%0d", $urandom_range(9));
    if (r < 6) return $sformatf("%0d", $urandom_range(999));
    if (r == 6) return $sformatf("%0d", $urandom);
    // Around the signed 32-bit limit
    if (r == 7) return $sformatf("%0d", 64'd2147483646 + $urandom_range(3));
    if (r == 8) return {"00", $sformatf("%0d", $urandom_range(99))};
    return "99999999999999999999";
  endfunction

  task automatic make_version();
    int n;
    int r;
    n = ($urandom_range(99) < 70) ? 3 : $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put(".");
      r = $urandom_range(19);
      if (r == 0) begin
        // leave the component empty
      end else if (r == 1) begin
        put("v1");
      end else if (r == 2) begin
        put_ws();
        put(number_text());
      end else if (r == 3) begin
        put(number_text());
        put("x");
      end else begin
        put(number_text());
      end
    end
    // Pre-release tag: mostly a known word, sometimes a stub or junk
    if ($urandom_range(99) < 60) begin
      put("-");
      r = $urandom_range(9);
      if (r < 8) put(tag_names[r % 3]);
      else if (r == 8) put(tag_stubs[$urandom_range(2)]);
      else put_byte(8'(8'h61 + $urandom_range(25)));
      if ($urandom_range(99) < 85) begin
        put_byte(8'($urandom_range(8'h21, 8'h7E)));
        if ($urandom_range(3) == 0) put_ws();
        if ($urandom_range(3) == 0) put("-");
        if ($urandom_range(9) != 0) put(number_text());
        if ($urandom_range(4) == 0) put(".1");
      end
    end
    // Build metadata with arbitrary bytes
    if ($urandom_range(3) == 0) begin
      put("+");
      repeat ($urandom_range(6)) put_byte(8'($urandom_range(255)));
    end
    if (str_buf.size() == 0) put("0");
    send_string();
  endtask

  task automatic make_noise();
    repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(255)));
    send_string();
  endtask

  // Hold the sender until every queued character is in and every result out
  task automatic wait_drained();
    while (pending_chars.size() != 0 || s_tvalid || expected_versions.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int target;
    clear_parser();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings: byte extremes, empty components, tag corner cases
    put_byte(8'hFF);
    send_string();
    put_byte(8'h00);
    send_string();
    put("1.2.3");
    send_string();
    put(".");
    send_string();
    put("7-rc");
    send_string();
    put("-beta_");
    send_string();
    put("x-q5");
    send_string();
    put("+");
    send_string();
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 25;
          rx_idle_pct = 74;
        end
        1: begin
          tx_idle_pct = 74;
          rx_idle_pct = 25;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // Stall the result side long enough for the input to back up
          @(posedge clk);
          hold_request = 1'b1;
        end
      endcase
      target = chars_queued + PHASE_CHARS;
      while (chars_queued < target) begin
        if ($urandom_range(9) == 0) make_noise();
        else make_version();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_versions.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", expected_versions.size()));
    if (mismatch_count == 0) $display("PASS semantic_version_parser");
    else $display("FAIL semantic_version_parser");
    $finish;
  end

endmodule
